### rtl/assert_macros.svh
// Assertion macros used by toroidal_cellular_automaton.sv; clock clk, reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a same-cycle property, off while in reset.
`define TCA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check: when ante holds, cons holds in the next cycle.
`define TCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tca_pkg.sv
// Shared constants, types and helpers of the toroidal cellular automaton.
package tca_pkg;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int CELL_W    = 2;
    localparam int ROW_AW    = $clog2(GRID_ROWS);
    localparam int CIDX_W    = $clog2(GRID_COLS);
    localparam int ROW_W     = GRID_COLS * CELL_W;
    localparam int ADDR_W    = ROW_AW + 1;   // bank bit on top of the row index
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [ROW_W-1:0]  row_word_t;
    typedef logic [ADDR_W-1:0] mem_addr_t;

    typedef struct packed {
        logic      we;
        mem_addr_t addr;
        row_word_t data;
    } mem_wr_t;

    typedef struct packed {
        logic      re;
        mem_addr_t addr;
    } mem_rd_t;

    localparam cell_t CELL_OFF  = 2'd0;
    localparam cell_t CELL_ON   = 2'd1;
    localparam cell_t CELL_REFR = 2'd2;
    localparam cell_t CELL_BAD  = 2'd3;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_GEN   = 2'd2;

    localparam logic [1:0] RULE_LIFE   = 2'd0;
    localparam logic [1:0] RULE_MORLEY = 2'd1;
    localparam logic [1:0] RULE_ASSIM  = 2'd2;
    localparam logic [1:0] RULE_BRAIN  = 2'd3;

    function automatic logic in_grid(logic [5:0] r, logic [5:0] c);
        return (int'(r) < GRID_ROWS) && (int'(c) < GRID_COLS);
    endfunction

endpackage

### rtl/tca_row_ram.sv
// Row-wide synchronous RAM holding both cell banks, one write and one read port.
module tca_row_ram (
    input  logic               clk,
    input  tca_pkg::mem_wr_t   wr,
    input  tca_pkg::mem_rd_t   rd,
    output tca_pkg::row_word_t rd_data
);

    tca_pkg::row_word_t mem [tca_pkg::MEM_DEPTH];
    tca_pkg::row_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.re)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/tca_cell_update.sv
// Neighbor count and next-state rule for one cell of the 3x3 window.
module tca_cell_update (
    input  logic [3*tca_pkg::CELL_W-1:0] up_win,   // {right, center, left}
    input  logic [3*tca_pkg::CELL_W-1:0] mid_win,
    input  logic [3*tca_pkg::CELL_W-1:0] dn_win,
    input  logic [1:0]                   rule,
    output tca_pkg::cell_t               next_cell
);

    tca_pkg::cell_t cur;
    logic [3:0]     n;
    logic           on;
    logic           live;

    assign cur = mid_win[tca_pkg::CELL_W +: tca_pkg::CELL_W];
    assign on  = (cur == tca_pkg::CELL_ON);

    always_comb
    begin
        n = 4'd0;
        for (int i = 0; i < 3; i++)
        begin
            n = n + 4'(up_win[i*tca_pkg::CELL_W +: tca_pkg::CELL_W] == tca_pkg::CELL_ON);
            n = n + 4'(dn_win[i*tca_pkg::CELL_W +: tca_pkg::CELL_W] == tca_pkg::CELL_ON);
        end
        n = n + 4'(mid_win[0 +: tca_pkg::CELL_W] == tca_pkg::CELL_ON);
        n = n + 4'(mid_win[2*tca_pkg::CELL_W +: tca_pkg::CELL_W] == tca_pkg::CELL_ON);
    end

    always_comb
    begin
        live = 1'b0;
        next_cell = tca_pkg::CELL_OFF;
        unique case (rule)
            tca_pkg::RULE_LIFE:
            begin
                live = on ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
                next_cell = live ? tca_pkg::CELL_ON : tca_pkg::CELL_OFF;
            end
            tca_pkg::RULE_MORLEY:
            begin
                live = on ? (n >= 4'd4 && n <= 4'd6) : (n == 4'd3 || n == 4'd4);
                next_cell = live ? tca_pkg::CELL_ON : tca_pkg::CELL_OFF;
            end
            tca_pkg::RULE_ASSIM:
            begin
                live = on ? (n >= 4'd4 && n <= 4'd7) : (n >= 4'd3 && n <= 4'd5);
                next_cell = live ? tca_pkg::CELL_ON : tca_pkg::CELL_OFF;
            end
            tca_pkg::RULE_BRAIN:
            begin
                live = (n == 4'd2);
                if (on)
                begin
                    next_cell = tca_pkg::CELL_REFR;
                end
                else if (cur == tca_pkg::CELL_REFR)
                begin
                    next_cell = tca_pkg::CELL_OFF;
                end
                else
                begin
                    next_cell = live ? tca_pkg::CELL_ON : tca_pkg::CELL_OFF;
                end
            end
            default:
            begin
                next_cell = tca_pkg::CELL_OFF;
            end
        endcase
    end

endmodule

### rtl/toroidal_cellular_automaton.sv
// Toroidal cellular automaton: 64x64 grid of 2-bit cells with four selectable rules.
// One item at a time. A cell write or read goes through the row RAM as a
// read-modify-write: the row is read on acceptance, written or read in S_CELL,
// and S_DONE hands the result to the output register and returns to idle. A
// generation loads the first three row windows through S_G_UP, S_G_MID, S_G_DN
// and S_G_CAP, steps through the cells one at a time while the windows rotate past
// a single next-state unit, and posts its result from S_DONE. During a row the RAM
// read port prefetches the row two below and the write port stores each finished
// row into the other bank. A result held by out_stall does not keep the next item
// out, but that item's result waits in S_DONE until the first is taken. After reset a
// clearing pass of both banks holds in_stall high; cfg writes are taken at any time.
`include "assert_macros.svh"

module toroidal_cellular_automaton (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [5:0] row,
    input  logic [5:0] col,
    input  logic [1:0] cell_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] ack_kind,
    output logic [1:0] read_state
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL,
        S_G_UP,
        S_G_MID,
        S_G_DN,
        S_G_CAP,
        S_G_ROW,
        S_DONE
    } state_t;

    localparam int CW = tca_pkg::CELL_W;
    localparam int RW = tca_pkg::ROW_W;
    localparam logic [tca_pkg::ROW_AW-1:0] LAST_ROW = tca_pkg::ROW_AW'(tca_pkg::GRID_ROWS - 1);
    localparam logic [tca_pkg::CIDX_W-1:0] LAST_COL = tca_pkg::CIDX_W'(tca_pkg::GRID_COLS - 1);

    state_t                      state_reg;
    logic                        live_bank_reg;
    logic [1:0]                  rule_reg;
    tca_pkg::mem_addr_t          clr_cnt_reg;
    logic [tca_pkg::ROW_AW-1:0]  row_cnt_reg;
    logic [tca_pkg::CIDX_W-1:0]  col_cnt_reg;
    logic                        out_valid_reg;
    logic [1:0]                  ack_kind_reg;
    logic [1:0]                  read_state_reg;

    // payload registers
    logic [1:0]                  kind_reg;
    logic [1:0]                  res_state_reg;
    logic [tca_pkg::ROW_AW-1:0]  row_reg;
    logic [tca_pkg::CIDX_W-1:0]  col_reg;
    tca_pkg::cell_t              wval_reg;
    logic                        inside_reg;
    tca_pkg::row_word_t          up_reg;
    tca_pkg::row_word_t          mid_reg;
    tca_pkg::row_word_t          dn_reg;
    tca_pkg::row_word_t          pre_reg;
    tca_pkg::row_word_t          dst_reg;

    tca_pkg::mem_wr_t            mem_wr;
    tca_pkg::mem_rd_t            mem_rd;
    tca_pkg::row_word_t          rd_data;
    tca_pkg::row_word_t          dst_next;
    tca_pkg::row_word_t          cell_word;
    tca_pkg::cell_t              new_cell;
    tca_pkg::cell_t              rd_cell;
    logic [tca_pkg::ROW_AW:0]    row_plus2;
    logic [tca_pkg::ROW_AW-1:0]  pf_row;
    logic                        in_acc;
    logic                        out_free;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign ack_kind   = ack_kind_reg;
    assign read_state = read_state_reg;

    // row prefetched during the current row: two ahead, wrapping
    always_comb
    begin
        row_plus2 = {1'b0, row_cnt_reg} + (tca_pkg::ROW_AW + 1)'(2);
        if (int'(row_plus2) >= tca_pkg::GRID_ROWS)
        begin
            row_plus2 = row_plus2 - (tca_pkg::ROW_AW + 1)'(tca_pkg::GRID_ROWS);
        end
        pf_row = row_plus2[tca_pkg::ROW_AW-1:0];
    end

    // window is taken at fixed places: cell c sits at the bottom of each rotating word
    tca_cell_update u_cell (
        .up_win    ({up_reg[CW +: CW],  up_reg[0 +: CW],  up_reg[RW-CW +: CW]}),
        .mid_win   ({mid_reg[CW +: CW], mid_reg[0 +: CW], mid_reg[RW-CW +: CW]}),
        .dn_win    ({dn_reg[CW +: CW],  dn_reg[0 +: CW],  dn_reg[RW-CW +: CW]}),
        .rule      (rule_reg),
        .next_cell (new_cell)
    );

    assign dst_next = {new_cell, dst_reg[RW-1:CW]};
    assign rd_cell  = rd_data[col_reg*CW +: CW];

    always_comb
    begin
        for (int i = 0; i < tca_pkg::GRID_COLS; i++)
        begin
            cell_word[i*CW +: CW] = (tca_pkg::CIDX_W'(i) == col_reg) ? wval_reg
                                                                       : rd_data[i*CW +: CW];
        end
    end

    tca_row_ram u_ram (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (rd_data)
    );

    always_comb
    begin
        mem_wr = '0;
        mem_rd = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = clr_cnt_reg;
                mem_wr.data = '0;
            end
            S_IDLE:
            begin
                mem_rd.re   = in_acc;
                mem_rd.addr = {live_bank_reg, tca_pkg::ROW_AW'(row)};
            end
            S_CELL:
            begin
                mem_wr.we   = (kind_reg == tca_pkg::REQ_WRITE) && inside_reg;
                mem_wr.addr = {live_bank_reg, row_reg};
                mem_wr.data = cell_word;
            end
            S_G_UP:
            begin
                mem_rd.re   = 1'b1;
                mem_rd.addr = {live_bank_reg, LAST_ROW};
            end
            S_G_MID:
            begin
                mem_rd.re   = 1'b1;
                mem_rd.addr = {live_bank_reg, tca_pkg::ROW_AW'(0)};
            end
            S_G_DN:
            begin
                mem_rd.re   = 1'b1;
                mem_rd.addr = {live_bank_reg, tca_pkg::ROW_AW'(1)};
            end
            S_G_ROW:
            begin
                mem_rd.re   = (col_cnt_reg == '0);
                mem_rd.addr = {live_bank_reg, pf_row};
                mem_wr.we   = (col_cnt_reg == LAST_COL);
                mem_wr.addr = {~live_bank_reg, row_cnt_reg};
                mem_wr.data = dst_next;
            end
            S_G_CAP, S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_reg <= tca_pkg::RULE_LIFE;
        end
        else if (cfg_we)
        begin
            rule_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            live_bank_reg  <= 1'b0;
            clr_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            col_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            ack_kind_reg   <= '0;
            read_state_reg <= '0;
        end
        else
        begin
            if (!out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == tca_pkg::ADDR_W'(tca_pkg::MEM_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        priority if (req_type == tca_pkg::REQ_WRITE ||
                                     req_type == tca_pkg::REQ_READ)
                        begin
                            state_reg <= S_CELL;
                        end
                        else if (req_type == tca_pkg::REQ_GEN)
                        begin
                            state_reg <= S_G_UP;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_CELL:
                begin
                    state_reg <= S_DONE;
                end
                S_G_UP:
                begin
                    state_reg <= S_G_MID;
                end
                S_G_MID:
                begin
                    state_reg <= S_G_DN;
                end
                S_G_DN:
                begin
                    state_reg <= S_G_CAP;
                end
                S_G_CAP:
                begin
                    row_cnt_reg <= '0;
                    col_cnt_reg <= '0;
                    state_reg   <= S_G_ROW;
                end
                S_G_ROW:
                begin
                    if (col_cnt_reg == LAST_COL)
                    begin
                        col_cnt_reg <= '0;
                        if (row_cnt_reg == LAST_ROW)
                        begin
                            live_bank_reg <= ~live_bank_reg;
                            state_reg     <= S_DONE;
                        end
                        else
                        begin
                            row_cnt_reg <= row_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_cnt_reg <= col_cnt_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        ack_kind_reg   <= kind_reg;
                        read_state_reg <= res_state_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kind_reg      <= req_type;
            res_state_reg <= tca_pkg::CELL_OFF;
            row_reg       <= tca_pkg::ROW_AW'(row);
            col_reg       <= tca_pkg::CIDX_W'(col);
            wval_reg      <= (cell_value == tca_pkg::CELL_BAD) ? tca_pkg::CELL_OFF : cell_value;
            inside_reg    <= tca_pkg::in_grid(row, col);
        end
        if (state_reg == S_CELL && kind_reg == tca_pkg::REQ_READ && inside_reg)
        begin
            res_state_reg <= rd_cell;
        end
        if (state_reg == S_G_MID)
        begin
            up_reg <= rd_data;
        end
        if (state_reg == S_G_DN)
        begin
            mid_reg <= rd_data;
        end
        if (state_reg == S_G_CAP)
        begin
            dn_reg <= rd_data;
        end
        if (state_reg == S_G_ROW)
        begin
            dst_reg <= dst_next;
            if (col_cnt_reg == tca_pkg::CIDX_W'(1))
            begin
                pre_reg <= rd_data;
            end
            if (col_cnt_reg == LAST_COL)
            begin
                // full turn done: windows are back in natural order, slide down one row
                up_reg <= {mid_reg[CW-1:0], mid_reg[RW-1:CW]};
                mid_reg <= {dn_reg[CW-1:0], dn_reg[RW-1:CW]};
                dn_reg <= pre_reg;
            end
            else
            begin
                up_reg  <= {up_reg[CW-1:0],  up_reg[RW-1:CW]};
                mid_reg <= {mid_reg[CW-1:0], mid_reg[RW-1:CW]};
                dn_reg  <= {dn_reg[CW-1:0],  dn_reg[RW-1:CW]};
            end
        end
    end

    `TCA_ASSERT(a_gen_writes_other_bank, (state_reg == S_G_ROW && mem_wr.we) |-> (mem_wr.addr[tca_pkg::ADDR_W-1] != live_bank_reg), "generation wrote the live bank")
    `TCA_ASSERT(a_bank_flip_at_gen_end, !$stable(live_bank_reg) |-> ($past(state_reg) == S_G_ROW && state_reg == S_DONE), "live bank changed outside generation end")
    `TCA_ASSERT(a_result_from_done, $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE), "result appeared without finishing an item")
    `TCA_ASSERT_NEXT(a_cell_item_finishes, (state_reg == S_CELL), (state_reg == S_DONE), "cell access did not finish in one cycle")

endmodule
